@@ rtl/core/stack_machine_execute_defines.svh @@
// Assertion macros used by the stack machine execute core.
`ifndef STACK_MACHINE_EXECUTE_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define SME_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sme_pkg.sv @@
package sme_pkg;

  typedef enum logic [3:0] {
    OP_NOP    = 4'd0,
    OP_PUSH   = 4'd1,
    OP_DUP    = 4'd2,
    OP_ADD    = 4'd3,
    OP_SUB    = 4'd4,
    OP_MUL    = 4'd5,
    OP_DIV    = 4'd6,
    OP_JMP    = 4'd7,
    OP_JMP_IF = 4'd8,
    OP_HALT   = 4'd9,
    OP_EQ     = 4'd10,
    OP_PRINT  = 4'd11
  } opcode_e;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_OVERFLOW  = 3'd1,
    ERR_UNDERFLOW = 3'd2,
    ERR_ILLEGAL   = 3'd3,
    ERR_DIVZERO   = 3'd4,
    ERR_POINTER   = 3'd5,
    ERR_OPERAND   = 3'd6
  } error_e;

  // Command from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } alu_cmd_t;

  // Status from the arithmetic unit back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

endpackage

@@ rtl/core/sme_muldiv.sv @@
// Iterative multiply and truncating divide, one bit per cycle.
module sme_muldiv import sme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  alu_cmd_t    cmd_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output alu_sts_t    sts_o,
  output logic [63:0] result_o
);

  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d, div_q, div_d, neg_q, neg_d;
  logic [63:0] acc_q, acc_d, opa_q, opa_d, opb_q, opb_d;
  logic [64:0] rem_shift, rem_sub;
  logic [63:0] mag_a, mag_b, res_fix;

  assign mag_a = a_i[63] ? (64'd0 - a_i) : a_i;
  assign mag_b = b_i[63] ? (64'd0 - b_i) : b_i;

  // Restoring division step: acc holds the remainder, opa the dividend/quotient.
  assign rem_shift = {acc_q, opa_q[63]};
  assign rem_sub   = rem_shift - {1'b0, opb_q};
  assign res_fix   = neg_q ? (64'd0 - opa_q) : opa_q;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    div_d  = div_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    opa_d  = opa_q;
    opb_d  = opb_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 7'd0;
      div_d  = cmd_i.is_div;
      neg_d  = a_i[63] ^ b_i[63];
      acc_d  = 64'd0;
      opa_d  = cmd_i.is_div ? mag_a : a_i;
      opb_d  = cmd_i.is_div ? mag_b : b_i;
    end else if (busy_q) begin
      if (div_q) begin
        if (!rem_sub[64]) begin
          acc_d = rem_sub[63:0];
          opa_d = {opa_q[62:0], 1'b1};
        end else begin
          acc_d = rem_shift[63:0];
          opa_d = {opa_q[62:0], 1'b0};
        end
      end else begin
        // Shift-add multiply, low 64 bits of the product in acc.
        if (opb_q[0]) begin
          acc_d = acc_q + opa_q;
        end
        opa_d = {opa_q[62:0], 1'b0};
        opb_d = {1'b0, opb_q[63:1]};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign result_o   = div_q ? res_fix : acc_q;

endmodule

@@ rtl/core/stack_machine_execute.sv @@
// Executes one stack machine instruction per accepted item and returns one
// result. The stack lives in a single-port synchronous memory; each
// instruction reads up to two entries in turn through the registered read
// port and writes back at most once, while multiply and divide also pass
// through the bit-serial arithmetic unit. The next item is accepted once
// the result register is free, so a result can wait while the next
// instruction runs.
module stack_machine_execute import sme_pkg::*; #(
  parameter int STACK_DEPTH      = 1024,
  parameter int MAX_PROGRAM_LEN  = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  opcode_i,
  input  logic [63:0] operand_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  error_code_o,
  output logic [63:0] next_pointer_o,
  output logic [10:0] depth_now_o,
  output logic        halted_flag_o,
  output logic        print_valid_o,
  output logic [63:0] print_value_o
);

`include "stack_machine_execute_defines.svh"

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD1   = 7'b0000010,
    S_RD2   = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_ALU   = 7'b0010000,
    S_WB    = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [63:0] ip_q, ip_d;
  logic        halt_q, halt_d;
  logic [10:0] plen_q;
  logic [3:0]  op_q;
  logic [63:0] opnd_q;
  logic [63:0] top_q, wdata_q, wdata_d;
  logic [2:0]  err_q, err_d;
  logic        pv_q, pv_d;
  logic [63:0] pval_q, pval_d;

  // Output register.
  logic        ov_q;
  logic [2:0]  oerr_q;
  logic [63:0] oip_q, opval_q;
  logic [10:0] ocnt_q;
  logic        ohalt_q, opv_q;

  // Stack memory, one port.
  logic [63:0] mem [STACK_DEPTH];
  logic        mwe;
  logic [AW-1:0] maddr;
  logic [63:0] mrdata;

  always_ff @(posedge clk_i) begin
    if (mwe) begin
      mem[maddr] <= wdata_q;
    end
    mrdata <= mem[maddr];
  end

  // Arithmetic unit; the second entry comes straight from the memory in the execute cycle.
  alu_cmd_t    acmd;
  alu_sts_t    asts;
  logic [63:0] ares;

  sme_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (acmd),
    .a_i     (mrdata),
    .b_i     (top_q),
    .sts_o   (asts),
    .result_o(ares)
  );

  logic [10:0] limit;
  logic        ip_bad, is_bin, out_free;
  logic [63:0] dup_idx;

  assign limit  = (32'(plen_q) < MAX_PROGRAM_LEN) ? plen_q : 11'(MAX_PROGRAM_LEN);
  assign ip_bad = ip_q[63] || (ip_q >= 64'(limit));
  assign is_bin = (op_q == OP_ADD) || (op_q == OP_SUB) || (op_q == OP_MUL) ||
                  (op_q == OP_DIV) || (op_q == OP_EQ);
  assign out_free = !ov_q || !out_stall_i;
  assign dup_idx  = 64'(cnt_q) - 64'd1 - opnd_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Sequencer: read the needed entries, compute, write back, report.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ip_d    = ip_q;
    halt_d  = halt_q;
    err_d   = err_q;
    pv_d    = pv_q;
    pval_d  = pval_q;
    wdata_d = wdata_q;
    mwe     = 1'b0;
    maddr   = AW'(cnt_q - CW'(1));
    acmd    = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_RD1;
        end
      end
      S_RD1: begin
        // Address the top entry, or the dup source.
        err_d  = ERR_OK;
        pv_d   = 1'b0;
        pval_d = 64'd0;
        if (op_q == OP_DUP) begin
          maddr = AW'(dup_idx);
        end
        state_d = S_RD2;
      end
      S_RD2: begin
        maddr   = AW'(cnt_q - CW'(2));
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        if (ip_bad) begin
          err_d = ERR_POINTER;
        end else if (is_bin) begin
          if (cnt_q < CW'(2)) begin
            err_d = ERR_UNDERFLOW;
          end else begin
            case (op_q)
              OP_ADD:  wdata_d = mrdata + top_q;
              OP_SUB:  wdata_d = mrdata - top_q;
              OP_EQ:   wdata_d = {63'd0, mrdata == top_q};
              default: wdata_d = 64'd0;
            endcase
            if (op_q == OP_DIV && top_q == 64'd0) begin
              err_d = ERR_DIVZERO;
            end else if (op_q == OP_MUL || op_q == OP_DIV) begin
              acmd.start  = 1'b1;
              acmd.is_div = (op_q == OP_DIV);
              state_d = S_ALU;
            end else begin
              state_d = S_WB;
            end
          end
        end else begin
          case (op_q)
            OP_NOP: ip_d = ip_q + 64'd1;
            OP_PUSH, OP_DUP: begin
              if (cnt_q >= FULL) begin
                err_d = ERR_OVERFLOW;
              end else if (op_q == OP_DUP && !opnd_q[63] && opnd_q >= 64'(cnt_q)) begin
                err_d = ERR_UNDERFLOW;
              end else if (op_q == OP_DUP && opnd_q[63]) begin
                err_d = ERR_OPERAND;
              end else begin
                wdata_d = (op_q == OP_PUSH) ? opnd_q : top_q;
                state_d = S_WB;
              end
            end
            OP_JMP: ip_d = opnd_q;
            OP_JMP_IF: begin
              if (cnt_q < CW'(2)) begin
                err_d = ERR_UNDERFLOW;
              end else if (top_q != 64'd0) begin
                cnt_d = cnt_q - CW'(1);
                ip_d  = opnd_q;
              end else begin
                ip_d = ip_q + 64'd1;
              end
            end
            OP_HALT: halt_d = 1'b1;
            OP_PRINT: begin
              if (cnt_q < CW'(1)) begin
                err_d = ERR_UNDERFLOW;
              end else begin
                pv_d   = 1'b1;
                pval_d = top_q;
                cnt_d  = cnt_q - CW'(1);
                ip_d   = ip_q + 64'd1;
              end
            end
            default: err_d = ERR_ILLEGAL;
          endcase
        end
      end
      S_ALU: begin
        if (asts.done) begin
          wdata_d = ares;
          state_d = S_WB;
        end
      end
      S_WB: begin
        // Binary ops overwrite the second entry; push and dup append.
        mwe  = 1'b1;
        ip_d = ip_q + 64'd1;
        if (is_bin) begin
          maddr = AW'(cnt_q - CW'(2));
          cnt_d = cnt_q - CW'(1);
        end else begin
          maddr = AW'(cnt_q);
          cnt_d = cnt_q + CW'(1);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ip_q    <= 64'd0;
      halt_q  <= 1'b0;
      plen_q  <= 11'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ip_q    <= ip_d;
      halt_q  <= halt_d;
      if (cfg_valid_i) begin
        plen_q <= cfg_data_i;
      end
      if (state_q == S_DONE && out_free) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload registers: instruction latch, operand capture, result transfer.
  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    pv_q    <= pv_d;
    pval_q  <= pval_d;
    wdata_q <= wdata_d;
    if (state_q == S_IDLE && in_valid_i) begin
      op_q   <= opcode_i;
      opnd_q <= operand_i;
    end
    if (state_q == S_RD2) begin
      top_q <= mrdata;
    end
    if (state_q == S_DONE && out_free) begin
      oerr_q  <= err_q;
      oip_q   <= ip_q;
      ocnt_q  <= 11'(cnt_q);
      ohalt_q <= halt_q;
      opv_q   <= pv_q;
      opval_q <= pval_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign error_code_o   = oerr_q;
  assign next_pointer_o = oip_q;
  assign depth_now_o    = ocnt_q;
  assign halted_flag_o  = ohalt_q;
  assign print_valid_o  = opv_q;
  assign print_value_o  = opval_q;

  `SME_ASSERT_IMP(a_depth_bound, clk_i, rst_ni, 1'b1, cnt_q <= FULL, "stack count overflow")
  `SME_ASSERT_NEXT(a_wb_done, clk_i, rst_ni, state_q == S_WB, state_q == S_DONE, "writeback skipped")
  `SME_ASSERT_IMP(a_alu_idle, clk_i, rst_ni, state_q == S_IDLE, !asts.busy, "alu busy when idle")

endmodule

@@ bench/stack_machine_execute_checker.sv @@
module stack_machine_execute_checker import sme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [3:0]  opcode_i,
  input  logic [63:0] operand_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  error_code_i,
  input  logic [63:0] next_pointer_i,
  input  logic [10:0] depth_now_i,
  input  logic        halted_flag_i,
  input  logic        print_valid_i,
  input  logic [63:0] print_value_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StackDepth = 1024;
  localparam int MaxProgramLen = 1024;

  typedef struct packed {
    logic [2:0]  err;
    logic [63:0] next_ptr;
    logic [10:0] depth;
    logic        halted;
    logic        pvalid;
    logic [63:0] pvalue;
  } step_result_t;

  // Mirror of the architectural state of the core.
  logic [63:0]  stack_mem [StackDepth];
  logic [10:0]  depth_q;
  logic [63:0]  ip_q;
  logic         halt_q;
  logic [10:0]  prog_len_q;
  step_result_t step_results_q[$];

  // Signed division truncating toward zero; the most negative value over -1 wraps.
  function automatic logic [63:0] trunc_quotient(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  // Executes one instruction on the mirrored state and returns its result.
  function automatic step_result_t execute_instr(logic [3:0] op, logic [63:0] opnd);
    step_result_t res;
    logic [63:0] lim;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    int n;
    res = '0;
    res.err = ERR_OK;
    n = int'(depth_q);
    lim = (prog_len_q < MaxProgramLen) ? 64'(prog_len_q) : 64'(MaxProgramLen);
    if (ip_q[63] || ip_q >= lim) begin
      res.err = ERR_POINTER;
    end else if (op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ}) begin
      if (n < 2) begin
        res.err = ERR_UNDERFLOW;
      end else begin
        a = stack_mem[10'(n-2)];
        b = stack_mem[10'(n-1)];
        r = '0;
        case (op)
          OP_ADD: r = a + b;
          OP_SUB: r = a - b;
          OP_MUL: r = a * b;
          OP_EQ:  r = (a == b) ? 64'd1 : 64'd0;
          default: begin
            if (b == '0) res.err = ERR_DIVZERO;
            else r = trunc_quotient(a, b);
          end
        endcase
        if (res.err == ERR_OK) begin
          stack_mem[10'(n-2)] = r;
          depth_q = 11'(n - 1);
          ip_q = ip_q + 1;
        end
      end
    end else begin
      case (op)
        OP_NOP: ip_q = ip_q + 1;
        OP_PUSH: begin
          if (n >= StackDepth) begin
            res.err = ERR_OVERFLOW;
          end else begin
            stack_mem[10'(n)] = opnd;
            depth_q = 11'(n + 1);
            ip_q = ip_q + 1;
          end
        end
        OP_DUP: begin
          if (n >= StackDepth) res.err = ERR_OVERFLOW;
          else if (!opnd[63] && opnd >= 64'(n)) res.err = ERR_UNDERFLOW;
          else if (opnd[63]) res.err = ERR_OPERAND;
          else begin
            stack_mem[10'(n)] = stack_mem[10'(n - 1 - int'(opnd))];
            depth_q = 11'(n + 1);
            ip_q = ip_q + 1;
          end
        end
        OP_JMP: ip_q = opnd;
        OP_JMP_IF: begin
          if (n < 2) begin
            res.err = ERR_UNDERFLOW;
          end else if (stack_mem[10'(n-1)] != '0) begin
            depth_q = 11'(n - 1);
            ip_q = opnd;
          end else begin
            ip_q = ip_q + 1;
          end
        end
        OP_HALT: halt_q = 1'b1;
        OP_PRINT: begin
          if (n < 1) begin
            res.err = ERR_UNDERFLOW;
          end else begin
            res.pvalid = 1'b1;
            res.pvalue = stack_mem[10'(n-1)];
            depth_q = 11'(n - 1);
            ip_q = ip_q + 1;
          end
        end
        default: res.err = ERR_ILLEGAL;
      endcase
    end
    res.next_ptr = ip_q;
    res.depth = depth_q;
    res.halted = halt_q;
    return res;
  endfunction

  assign pending_o = step_results_q.size();

  // Track transfers on all three channels and compare each result.
  always @(posedge clk_i or negedge rst_ni) begin
    step_result_t want;
    step_result_t got;
    if (!rst_ni) begin
      depth_q = '0;
      ip_q = '0;
      halt_q = 1'b0;
      prog_len_q = '0;
      fail_count_o <= 0;
      step_results_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) prog_len_q = cfg_data_i;
      if (in_valid_i && !in_stall_i) step_results_q.push_back(execute_instr(opcode_i, operand_i));
      if (out_valid_i && !out_stall_i) begin
        got = {error_code_i, next_pointer_i, depth_now_i, halted_flag_i,
               print_valid_i, print_value_i};
        if (step_results_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("Result transfer with nothing outstanding");
        end else begin
          want = step_results_q.pop_front();
          if (got !== want) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10) begin
              $display("Result mismatch: expected err=%0d ptr=%h depth=%0d halt=%b pv=%b val=%h",
                       want.err, want.next_ptr, want.depth, want.halted, want.pvalid,
                       want.pvalue);
              $display("                 actual   err=%0d ptr=%h depth=%0d halt=%b pv=%b val=%h",
                       got.err, got.next_ptr, got.depth, got.halted, got.pvalid, got.pvalue);
            end
          end
        end
      end
    end
  end

endmodule

@@ bench/stack_machine_execute_tb.sv @@
module stack_machine_execute_tb import sme_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [10:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  opcode_i = '0;
  logic [63:0] operand_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  error_code_o;
  logic [63:0] next_pointer_o;
  logic [10:0] depth_now_o;
  logic        halted_flag_o;
  logic        print_valid_o;
  logic [63:0] print_value_o;
  int          fail_count;
  int          pending;
  int          instr_sent = 0;
  int          settings_used = 0;
  bit          no_gaps = 1'b0;

  stack_machine_execute DUT (.*);

  stack_machine_execute_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .opcode_i, .operand_i,
    .out_valid_i(out_valid_o), .out_stall_i, .error_code_i(error_code_o),
    .next_pointer_i(next_pointer_o), .depth_now_i(depth_now_o),
    .halted_flag_i(halted_flag_o), .print_valid_i(print_valid_o),
    .print_value_i(print_value_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 19);
    if (no_gaps || pick < 12) return 0;
    if (pick < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random back pressure on the result channel.
  always @(posedge clk_i) begin
    out_stall_i <= (gap_len() != 0);
  end

  task automatic send_instr(opcode_e op, logic [63:0] opnd);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    operand_i <= opnd;
    do @(posedge clk_i); while (in_stall_o);
    instr_sent++;
  endtask

  task automatic send_raw_op(logic [3:0] op, logic [63:0] opnd);
    send_instr(opcode_e'(op), opnd);
  endtask

  // Waits until every result has come back, then writes the program length.
  task automatic set_length(logic [10:0] len);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [63:0] rand_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return 64'($signed($urandom_range(0, 20)) - 10);
    if (pick == 4) return {$urandom, $urandom};
    if (pick == 5) return 64'h8000_0000_0000_0000;
    if (pick == 6) return 64'h7fff_ffff_ffff_ffff;
    if (pick == 7) return '1;
    return 64'($urandom);
  endfunction

  // Random instruction mix; a jump every 16 keeps the pointer inside the program.
  task automatic random_phase(int count, int target_max);
    int pick;
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 15) begin
        send_instr(OP_JMP, 64'($urandom_range(0, target_max)));
        continue;
      end
      pick = $urandom_range(0, 99);
      if (i % 40 == 0) no_gaps = ~no_gaps;
      if (pick < 30) send_instr(OP_PUSH, rand_value());
      else if (pick < 38) send_instr(OP_DUP, 64'($urandom_range(0, 3)));
      else if (pick < 40) send_instr(OP_DUP, rand_value());
      else if (pick < 48) send_instr(OP_ADD, rand_value());
      else if (pick < 55) send_instr(OP_SUB, rand_value());
      else if (pick < 61) send_instr(OP_MUL, rand_value());
      else if (pick < 67) send_instr(OP_DIV, rand_value());
      else if (pick < 73) send_instr(OP_EQ, rand_value());
      else if (pick < 81) send_instr(OP_PRINT, rand_value());
      else if (pick < 86) send_instr(OP_JMP_IF, 64'($urandom_range(0, target_max)));
      else if (pick < 90) send_instr(OP_NOP, rand_value());
      else if (pick < 92) send_instr(OP_HALT, rand_value());
      else if (pick < 95) send_raw_op(4'($urandom_range(12, 15)), rand_value());
      else send_instr(OP_JMP, 64'($urandom_range(0, target_max)));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    #(20ns * 3_000_000);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty program: every fetch is a bad pointer.
    set_length(11'd0);
    send_instr(OP_NOP, '0);
    send_instr(OP_PUSH, 64'd5);

    // Directed: most operations, several error paths and the division corner.
    set_length(11'd1024);
    send_instr(OP_PRINT, '0);
    send_instr(OP_ADD, '0);
    send_instr(OP_DUP, '0);
    send_instr(OP_PUSH, 64'h8000_0000_0000_0000);
    send_instr(OP_JMP_IF, 64'd3);
    send_instr(OP_PUSH, '1);
    send_instr(OP_DIV, '0);
    send_instr(OP_PUSH, '0);
    send_instr(OP_DIV, '0);
    send_instr(OP_DUP, 64'd2);
    send_instr(OP_DUP, '1);
    send_instr(OP_DUP, 64'd1);
    send_instr(OP_JMP_IF, 64'd40);
    send_instr(OP_PUSH, 64'h7fff_ffff_ffff_ffff);
    send_instr(OP_ADD, '0);
    send_instr(OP_PUSH, 64'd3);
    send_instr(OP_MUL, '0);
    send_instr(OP_PUSH, 64'd9);
    send_instr(OP_SUB, '0);
    send_instr(OP_DUP, '0);
    send_instr(OP_EQ, '0);
    send_instr(OP_JMP_IF, 64'd7);
    send_instr(OP_HALT, '0);
    send_raw_op(4'd15, '0);
    send_instr(OP_PRINT, '0);

    // A one-instruction program, then the capped maximum length.
    set_length(11'd1);
    send_instr(OP_JMP, '0);
    send_instr(OP_NOP, '0);
    send_instr(OP_NOP, '0);
    set_length(11'd2047);
    random_phase(70, 900);

    // Fill the stack to the top to reach overflow on push and dup.
    set_length(11'd1024);
    for (int i = 0; i < 1100; i++) begin
      if (i % 16 == 15) send_instr(OP_JMP, '0);
      else send_instr(OP_PUSH, {$urandom, $urandom});
    end
    send_instr(OP_DUP, '0);
    random_phase(60, 900);

    set_length(11'd600);
    random_phase(60, 500);

    // Pointer pushed out of range for good: past the end, where even a jump to a negative target reports a bad pointer.
    set_length(11'd1024);
    random_phase(30, 900);
    send_instr(OP_JMP, 64'd1500);
    send_instr(OP_NOP, '0);
    set_length(11'd2047);
    send_instr(OP_JMP, '1);
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Executed %0d instructions across %0d program length settings,", instr_sent,
             settings_used);
    $display("including a full stack, division corners and out-of-range pointers.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ stack_machine_execute.f @@
+incdir+rtl/core
rtl/core/sme_pkg.sv
rtl/core/sme_muldiv.sv
rtl/core/stack_machine_execute.sv
bench/stack_machine_execute_checker.sv
bench/stack_machine_execute_tb.sv
